// ===== hdl/mtwa_pkg.sv =====
// ----------------------------------------------------------------------------
// mtwa_pkg: shared constants and types of the tare window averager
// Sizes, divisor reciprocals and the stage control record used by all lanes.
// ----------------------------------------------------------------------------
package mtwa_pkg;

  localparam int unsigned LANES       = 6;
  localparam int unsigned CHANNELS    = 6;
  localparam int unsigned WINDOW_LEN  = 10;
  localparam int unsigned CAL_LEN     = 100;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned VALUE_BITS  = 25;

  localparam int unsigned MAX_LEN  = (CAL_LEN > WINDOW_LEN) ? CAL_LEN : WINDOW_LEN;
  localparam int unsigned CNT_BITS = $clog2(MAX_LEN + 1);

  // reciprocal multiply: floor(x * K >> S) == x / d for x < 2^SAMPLE_BITS
  localparam int unsigned MUL_BITS  = SAMPLE_BITS + 1;
  localparam int unsigned PROD_BITS = SAMPLE_BITS + MUL_BITS;
  localparam int unsigned SHIFT_WIN = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int unsigned SHIFT_CAL = SAMPLE_BITS + $clog2(CAL_LEN);
  localparam longint unsigned MUL_WIN = ((64'd1 << SHIFT_WIN) / WINDOW_LEN) + 64'd1;
  localparam longint unsigned MUL_CAL = ((64'd1 << SHIFT_CAL) / CAL_LEN) + 64'd1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [VALUE_BITS-1:0]  value_t;

  typedef struct packed {
    logic valid;
    logic cal;
    logic clear;
    logic emit;
  } stage_t;

endpackage

// ===== hdl/multichannel_tare_window_averager.sv =====
// ----------------------------------------------------------------------------
// multichannel_tare_window_averager: six-channel boxcar average with tare
// Averages sample sets over a window, subtracts calibrated offsets, and
// calibrates the offsets after reset or on command.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  in      | in_valid_i / in_ready_o | command_i, sample_0_i .. sample_5_i
//  out     | out_valid_o/out_ready_i | kind_o, value_0_o .. value_5_o
//
//  One transaction per cycle while the input is not stalled; a result appears
//  once the transaction that completes its window or calibration has passed
//  three lane stages (reciprocal multiply, quotient, accumulate) and the output register.
//  After reset the block calibrates over the first CAL_LEN transactions.
//  Input stalls only while an emitting transaction meets an untaken result.
// ----------------------------------------------------------------------------
module multichannel_tare_window_averager (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [23:0] sample_0_i,
  input  logic [23:0] sample_1_i,
  input  logic [23:0] sample_2_i,
  input  logic [23:0] sample_3_i,
  input  logic [23:0] sample_4_i,
  input  logic [23:0] sample_5_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [24:0] value_0_o,
  output logic [24:0] value_1_o,
  output logic [24:0] value_2_o,
  output logic [24:0] value_3_o,
  output logic [24:0] value_4_o,
  output logic [24:0] value_5_o
);

  logic              en;
  mtwa_pkg::stage_t  stg_a, stg_b, stg_c;
  mtwa_pkg::sample_t samples [mtwa_pkg::LANES];
  mtwa_pkg::value_t  values  [mtwa_pkg::LANES];

  assign samples[0] = sample_0_i;
  assign samples[1] = sample_1_i;
  assign samples[2] = sample_2_i;
  assign samples[3] = sample_3_i;
  assign samples[4] = sample_4_i;
  assign samples[5] = sample_5_i;

  mtwa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .en_o        (en),
    .stg_a_o     (stg_a),
    .stg_b_o     (stg_b),
    .stg_c_o     (stg_c),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o)
  );

  for (genvar g = 0; g < mtwa_pkg::LANES; g++) begin : g_lane
    if (g < mtwa_pkg::CHANNELS) begin : g_used
      mtwa_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (en),
        .sample_i (samples[g]),
        .stg_a_i  (stg_a),
        .stg_b_i  (stg_b),
        .stg_c_i  (stg_c),
        .value_o  (values[g])
      );
    end else begin : g_unused
      assign values[g] = '0;
    end
  end

  assign value_0_o = values[0];
  assign value_1_o = values[1];
  assign value_2_o = values[2];
  assign value_3_o = values[3];
  assign value_4_o = values[4];
  assign value_5_o = values[5];

endmodule

// ===== hdl/mtwa_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtwa_ctrl: sequencing and merge control of the tare window averager
// Tracks mode and set count at acceptance, carries stage records down the
// pipeline, and holds the result valid and kind.
// ----------------------------------------------------------------------------
module mtwa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            command_i,
  input  logic            out_ready_i,
  output logic            in_ready_o,
  output logic            en_o,
  output mtwa_pkg::stage_t stg_a_o,
  output mtwa_pkg::stage_t stg_b_o,
  output mtwa_pkg::stage_t stg_c_o,
  output logic            out_valid_o,
  output logic            kind_o
);

  logic                             cal_q, cal_d;
  logic [mtwa_pkg::CNT_BITS-1:0]    cnt_q, cnt_d;
  logic [mtwa_pkg::CNT_BITS-1:0]    cnt_base, cnt_inc, limit;
  logic                             eff_cal, emit, accept, en;
  mtwa_pkg::stage_t                 new_stg;
  mtwa_pkg::stage_t                 stg_a_q, stg_b_q, stg_c_q;
  logic                             out_valid_q, out_valid_d;
  logic                             kind_q;

  // stall only when an emitting transaction meets a full, untaken output
  assign en         = !(stg_c_q.valid && stg_c_q.emit && out_valid_q && !out_ready_i);
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;

  always_comb begin
    eff_cal  = command_i | cal_q;
    cnt_base = command_i ? '0 : cnt_q;
    cnt_inc  = cnt_base + mtwa_pkg::CNT_BITS'(1);
    limit    = eff_cal ? mtwa_pkg::CNT_BITS'(mtwa_pkg::CAL_LEN)
                       : mtwa_pkg::CNT_BITS'(mtwa_pkg::WINDOW_LEN);
    emit     = (cnt_inc >= limit);

    cal_d = cal_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (emit) begin
        cnt_d = '0;
        cal_d = 1'b0;
      end else begin
        cnt_d = cnt_inc;
        cal_d = eff_cal;
      end
    end

    new_stg.valid = accept;
    new_stg.cal   = eff_cal;
    new_stg.clear = command_i;
    new_stg.emit  = emit;

    out_valid_d = out_valid_q;
    if (en && stg_c_q.valid && stg_c_q.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q       <= 1'b1;
      cnt_q       <= '0;
      stg_a_q     <= '0;
      stg_b_q     <= '0;
      stg_c_q     <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= 1'b0;
    end else begin
      cal_q       <= cal_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (en) begin
        stg_a_q <= new_stg;
        stg_b_q <= stg_a_q;
        stg_c_q <= stg_b_q;
        if (stg_c_q.valid && stg_c_q.emit) begin
          kind_q <= stg_c_q.cal;
        end
      end
    end
  end

  assign en_o        = en;
  assign stg_a_o     = stg_a_q;
  assign stg_b_o     = stg_b_q;
  assign stg_c_o     = stg_c_q;
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;

endmodule

// ===== hdl/mtwa_lane.sv =====
// ----------------------------------------------------------------------------
// mtwa_lane: one channel of the tare window averager
// Divides the sample by the window or calibration length through a
// reciprocal multiply, accumulates the sum or offset and forms the result.
// ----------------------------------------------------------------------------
module mtwa_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  mtwa_pkg::sample_t sample_i,
  input  mtwa_pkg::stage_t  stg_a_i,
  input  mtwa_pkg::stage_t  stg_b_i,
  input  mtwa_pkg::stage_t  stg_c_i,
  output mtwa_pkg::value_t  value_o
);

  mtwa_pkg::sample_t                  sample_q;
  logic [mtwa_pkg::SAMPLE_BITS-1:0]   mag;
  logic [mtwa_pkg::MUL_BITS-1:0]      mul_k;
  logic [mtwa_pkg::PROD_BITS-1:0]     prod_d, prod_q;
  logic                               neg_q;
  logic [mtwa_pkg::PROD_BITS-1:0]     shifted;
  logic [mtwa_pkg::SAMPLE_BITS-1:0]   q_mag;
  mtwa_pkg::sample_t                  quot_d, quot_q;
  mtwa_pkg::value_t                   q_ext, sum_q, off_q, off_base, off_new, sum_new, corr;
  mtwa_pkg::value_t                   value_q;

  always_comb begin
    mag    = sample_q[mtwa_pkg::SAMPLE_BITS-1] ? (-sample_q) : sample_q;
    mul_k  = stg_a_i.cal ? mtwa_pkg::MUL_BITS'(mtwa_pkg::MUL_CAL)
                         : mtwa_pkg::MUL_BITS'(mtwa_pkg::MUL_WIN);
    prod_d = mtwa_pkg::PROD_BITS'(mag) * mtwa_pkg::PROD_BITS'(mul_k);

    shifted = stg_b_i.cal ? (prod_q >> mtwa_pkg::SHIFT_CAL) : (prod_q >> mtwa_pkg::SHIFT_WIN);
    q_mag   = shifted[mtwa_pkg::SAMPLE_BITS-1:0];
    quot_d  = neg_q ? (-q_mag) : q_mag;

    q_ext    = mtwa_pkg::VALUE_BITS'(quot_q);
    off_base = stg_c_i.clear ? '0 : off_q;
    off_new  = off_base + q_ext;
    sum_new  = sum_q + q_ext;
    corr     = sum_new - off_q;
  end

  // payload pipeline: hold on stall
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sample_q <= sample_i;
      prod_q   <= prod_d;
      neg_q    <= sample_q[mtwa_pkg::SAMPLE_BITS-1];
      quot_q   <= quot_d;
      if (stg_c_i.valid && stg_c_i.emit) begin
        value_q <= stg_c_i.cal ? off_new : corr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      off_q <= '0;
    end else if (en_i && stg_c_i.valid) begin
      if (stg_c_i.cal) begin
        off_q <= off_new;
        sum_q <= '0;
      end else begin
        sum_q <= stg_c_i.emit ? '0 : sum_new;
      end
    end
  end

  assign value_o = value_q;

endmodule
